@@ rtl/zrlrd_pkg.sv @@
package zrlrd_pkg;

   localparam int CSR_W      = 14;   // row_bytes register width
   localparam int BYTE_W     = 8;
   localparam int CNT_W      = 8;    // zero run count, one compressed byte
   localparam int WORD_W     = 64;   // row_word field width
   localparam int VALID_W    = 4;    // bytes_valid field width
   localparam int RSP_DATA_W = 72;   // row_word + bytes_valid, padded to bytes

   // Outcome of one step of the shared byte/run unit.
   typedef struct packed {
      logic emit;   // word is full or the row ended
      logic last;   // row ended with this step
   } step_flags_type;

endpackage

@@ rtl/zrlrd_step.sv @@
// Shared step unit: adds either one literal byte or a chunk of zero bytes.
// A chunk stops at the word boundary, at the row end, or when the run is used up.
module zrlrd_step
   import zrlrd_pkg::*;
#(
   parameter int WORD_BYTES = 8,
   parameter int POS_W      = 14,
   parameter int FILL_W     = 4
) (
   input  logic              run,
   input  logic [CNT_W-1:0]  cnt,
   input  logic [FILL_W-1:0] fill,
   input  logic [POS_W-1:0]  pos,
   input  logic [POS_W-1:0]  len,
   output logic [FILL_W-1:0] k,
   output logic [FILL_W-1:0] fill_next,
   output logic [POS_W-1:0]  pos_next,
   output step_flags_type    flags
);

   localparam int MW = (POS_W > CNT_W) ? POS_W : CNT_W;

   logic [MW-1:0] left;
   logic [MW-1:0] room;
   logic [MW-1:0] run_cnt;
   logic [MW-1:0] m1;
   logic [MW-1:0] m2;

   always_comb begin
      left    = MW'(len - pos);
      room    = MW'(FILL_W'(WORD_BYTES) - fill);
      run_cnt = MW'(cnt);
      m1      = (run_cnt < room) ? run_cnt : room;
      m2      = (m1 < left) ? m1 : left;
      k       = run ? FILL_W'(m2) : FILL_W'(1);
      fill_next  = fill + k;
      pos_next   = pos + POS_W'(k);
      flags.last = (pos_next == len);
      flags.emit = (fill_next == FILL_W'(WORD_BYTES)) || flags.last;
   end

endmodule

@@ rtl/zrlrd_out.sv @@
// Output register stage for decoded words.
module zrlrd_out
   import zrlrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [WORD_W-1:0]     word,
   input  logic [VALID_W-1:0]    count,
   input  logic                  last,
   input  logic                  ovf,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [RSP_DATA_W-1:0] data_ff;
   logic                  last_ff;
   logic                  ovf_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {{(RSP_DATA_W - WORD_W - VALID_W){1'b0}}, count, word};
         last_ff <= last;
         ovf_ff  <= ovf;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = ovf_ff;

endmodule

@@ rtl/zero_run_length_row_decoder.sv @@
// Zero-run-length decoder for one visibility row. A literal byte or a zero
// marker is handled as it is taken. A count byte loads the run, then the
// shared step unit adds zeros a chunk per cycle while the output register is
// free, one chunk per output word; input is not taken while a run is in
// progress or while the output register holds a word that is not taken.
// Writing csr_wdata restarts the row (partial word, pending marker, overrun
// flag are dropped); 0 is taken as 1 and values above MAX_ROW_BYTES as the max.
module zero_run_length_row_decoder
   import zrlrd_pkg::*;
#(
   parameter int MAX_ROW_BYTES = 8192,
   parameter int WORD_BYTES    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_W-1:0]      csr_wdata,   // row_bytes
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] comp_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [63:0] row_word, [67:64] bytes_valid
   output logic                  rsp_tlast,   // last_of_row
   output logic                  rsp_tuser    // overrun
);

   localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
   localparam int FILL_W = $clog2(WORD_BYTES + 1);
   localparam int IDX_W  = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
   localparam int CMP_W  = (POS_W > CSR_W) ? POS_W : CSR_W;
   localparam int LW     = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam int RESET_ROW = (MAX_ROW_BYTES < 8192) ? MAX_ROW_BYTES : 8192;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                  state_ff, state_in;
   logic [POS_W-1:0]      len_ff, len_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  await_ff, await_in;
   logic                  ovf_ff, ovf_in;
   logic [BYTE_W-1:0]     buf_ff [WORD_BYTES];
   logic [BYTE_W-1:0]     buf_in [WORD_BYTES];
   logic [BYTE_W-1:0]     buf_next [WORD_BYTES];

   logic [FILL_W-1:0]     k;
   logic [FILL_W-1:0]     fill_next;
   logic [POS_W-1:0]      pos_next;
   step_flags_type        flags;

   logic                  out_free;
   logic                  out_load;
   logic [WORD_W-1:0]     out_word;
   logic                  out_last;
   logic                  out_ovf;

   logic                  take_in;
   logic [CMP_W-1:0]      wr_val;
   logic [LW-1:0]         left;
   logic [LW-1:0]         req_cnt;
   logic                  run_over;
   logic [CNT_W-1:0]      run_left;

   zrlrd_step #(
      .WORD_BYTES (WORD_BYTES),
      .POS_W      (POS_W),
      .FILL_W     (FILL_W)
   ) u_step (
      .run       (state_ff == ST_RUN),
      .cnt       (cnt_ff),
      .fill      (fill_ff),
      .pos       (pos_ff),
      .len       (len_ff),
      .k         (k),
      .fill_next (fill_next),
      .pos_next  (pos_next),
      .flags     (flags)
   );

   zrlrd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .word       (out_word),
      .count      (VALID_W'(fill_next)),
      .last       (out_last),
      .ovf        (out_ovf),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign take_in    = req_tvalid && req_tready;

   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         buf_next[i] = buf_ff[i];
      end
      if (state_ff == ST_IDLE) begin
         buf_next[fill_ff[IDX_W-1:0]] = req_tdata;
      end
      out_word = '0;
      for (int i = 0; i < WORD_BYTES; i++) begin
         out_word[BYTE_W*i +: BYTE_W] = buf_next[i];
      end
   end

   // count byte clamp against bytes left in the row
   always_comb begin
      left     = LW'(len_ff - pos_ff);
      req_cnt  = LW'(req_tdata);
      run_over = req_cnt > left;
      run_left = run_over ? CNT_W'(left) : req_tdata;
   end

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      fill_in  = fill_ff;
      cnt_in   = cnt_ff;
      await_in = await_ff;
      ovf_in   = ovf_ff;
      for (int i = 0; i < WORD_BYTES; i++) begin
         buf_in[i] = buf_ff[i];
      end
      out_load = 1'b0;
      out_last = flags.last;
      out_ovf  = flags.last && ovf_ff;
      wr_val   = CMP_W'(csr_wdata);

      if (csr_we) begin
         if (wr_val == '0) begin
            len_in = POS_W'(1);
         end else if (wr_val > CMP_W'(MAX_ROW_BYTES)) begin
            len_in = POS_W'(MAX_ROW_BYTES);
         end else begin
            len_in = POS_W'(wr_val);
         end
         state_in = ST_IDLE;
         pos_in   = '0;
         fill_in  = '0;
         await_in = 1'b0;
         ovf_in   = 1'b0;
         for (int i = 0; i < WORD_BYTES; i++) begin
            buf_in[i] = '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (take_in) begin
                  if (await_ff) begin
                     await_in = 1'b0;
                     ovf_in   = ovf_ff || run_over;
                     cnt_in   = run_left;
                     if (run_left != '0) begin
                        state_in = ST_RUN;
                     end
                  end else if (req_tdata != '0) begin
                     pos_in  = pos_next;
                     fill_in = fill_next;
                     for (int i = 0; i < WORD_BYTES; i++) begin
                        buf_in[i] = buf_next[i];
                     end
                     if (flags.emit) begin
                        out_load = 1'b1;
                        fill_in  = '0;
                        for (int i = 0; i < WORD_BYTES; i++) begin
                           buf_in[i] = '0;
                        end
                        if (flags.last) begin
                           pos_in = '0;
                           ovf_in = 1'b0;
                        end
                     end
                  end else begin
                     await_in = 1'b1;
                  end
               end
            end
            ST_RUN: begin
               if (out_free) begin
                  // zeros: buffer bytes above the fill are already clear
                  pos_in  = pos_next;
                  fill_in = fill_next;
                  cnt_in  = cnt_ff - CNT_W'(k);
                  if (flags.emit) begin
                     out_load = 1'b1;
                     fill_in  = '0;
                     for (int i = 0; i < WORD_BYTES; i++) begin
                        buf_in[i] = '0;
                     end
                     if (flags.last) begin
                        pos_in = '0;
                        ovf_in = 1'b0;
                     end
                  end
                  if (cnt_ff == CNT_W'(k)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= POS_W'(RESET_ROW);
         pos_ff   <= '0;
         fill_ff  <= '0;
         cnt_ff   <= '0;
         await_ff <= 1'b0;
         ovf_ff   <= 1'b0;
         for (int i = 0; i < WORD_BYTES; i++) begin
            buf_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         await_ff <= await_in;
         ovf_ff   <= ovf_in;
         for (int i = 0; i < WORD_BYTES; i++) begin
            buf_ff[i] <= buf_in[i];
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_pos_in_row: assert property (@(posedge clock) disable iff (reset)
      pos_ff < len_ff)
      else $error("row position reached row length");

   a_fill_below_word: assert property (@(posedge clock) disable iff (reset)
      fill_ff < FILL_W'(WORD_BYTES))
      else $error("word fill not drained");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> cnt_ff != '0)
      else $error("zero run active with empty count");

   a_ovf_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tuser)
      else $error("overrun flagged on non-final word");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[WORD_W +: VALID_W] != '0)
         && (rsp_tdata[WORD_W +: VALID_W] <= VALID_W'(WORD_BYTES)))
      else $error("bytes_valid out of range");
`endif

endmodule

@@ dv/zero_run_length_row_decoder_checker.sv @@
`timescale 1ns / 1ps

module zero_run_length_row_decoder_checker
   import zrlrd_pkg::*;
#(
   parameter int MAX_ROW_BYTES = 8192,
   parameter int WORD_BYTES    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tuser,
   output int                    fail_count,
   output int                    words_pending,
   output int                    words_checked,
   output int                    rows_checked,
   output int                    clamped_rows
);

   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [VALID_W-1:0] nbytes;
      logic               last;
      logic               clamped;
   } row_word_type;

   row_word_type      row_word_q[$];

   logic [CSR_W-1:0]  row_bytes_reg;
   int unsigned       row_pos;
   int unsigned       fill;
   logic              await_count;
   logic              clamp_seen;
   logic [WORD_W-1:0] pack_buf;

   int errs   = 0;
   int words  = 0;
   int rows   = 0;
   int clamps = 0;

   function automatic int unsigned decoded_row_len();
      int unsigned n;
      n = row_bytes_reg;
      if (n == 0) n = 1;
      if (n > MAX_ROW_BYTES) n = MAX_ROW_BYTES;
      return n;
   endfunction

   function automatic void clear_row();
      row_pos     = 0;
      fill        = 0;
      await_count = 1'b0;
      clamp_seen  = 1'b0;
      pack_buf    = '0;
   endfunction

   function automatic void pack_byte(input logic [BYTE_W-1:0] b);
      row_word_type w;
      logic         row_end;
      pack_buf[8*fill +: 8] = b;
      fill++;
      row_pos++;
      row_end = (row_pos >= decoded_row_len());
      if (fill >= WORD_BYTES || row_end) begin
         w.word    = pack_buf;
         w.nbytes  = VALID_W'(fill);
         w.last    = row_end;
         w.clamped = row_end && clamp_seen;
         row_word_q.push_back(w);
         pack_buf = '0;
         fill     = 0;
         if (row_end) clear_row();
      end
   endfunction

   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      int unsigned len;
      int unsigned left;
      int unsigned run;
      if (await_count) begin
         len  = decoded_row_len();
         left = (len > row_pos) ? len - row_pos : 0;
         run  = b;
         await_count = 1'b0;
         // run past the row end: clamp and flag the row
         if (run > left) begin
            run        = left;
            clamp_seen = 1'b1;
         end
         repeat (run) pack_byte('0);
      end else if (b != 0) begin
         pack_byte(b);
      end else begin
         await_count = 1'b1;
      end
   endfunction

   function automatic void log_fail(input string msg);
      errs++;
      if (errs <= 10) $display("%t  %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      row_word_type w;
      if (reset) begin
         row_bytes_reg = CSR_W'(8192);
         clear_row();
         row_word_q.delete();
      end else begin
         // a row_bytes write restarts the row
         if (csr_we) begin
            row_bytes_reg = csr_wdata;
            clear_row();
         end
         if (req_tvalid && req_tready) decode_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (row_word_q.size() == 0) begin
               log_fail($sformatf("unexpected row word %h bytes=%0d last=%b ovr=%b",
                  rsp_tdata[WORD_W-1:0], rsp_tdata[WORD_W +: VALID_W],
                  rsp_tlast, rsp_tuser));
            end else begin
               w = row_word_q.pop_front();
               words++;
               if (w.last) rows++;
               if (w.clamped) clamps++;
               if (rsp_tdata[WORD_W-1:0] !== w.word ||
                   rsp_tdata[WORD_W +: VALID_W] !== w.nbytes ||
                   rsp_tlast !== w.last || rsp_tuser !== w.clamped) begin
                  log_fail($sformatf({"row word mismatch: expected %h bytes=%0d last=%b ",
                     "ovr=%b, got %h bytes=%0d last=%b ovr=%b"},
                     w.word, w.nbytes, w.last, w.clamped,
                     rsp_tdata[WORD_W-1:0], rsp_tdata[WORD_W +: VALID_W],
                     rsp_tlast, rsp_tuser));
               end
            end
         end
      end
      fail_count    <= errs;
      words_pending <= row_word_q.size();
      words_checked <= words;
      rows_checked  <= rows;
      clamped_rows  <= clamps;
   end

endmodule

@@ dv/zero_run_length_row_decoder_test.sv @@
`timescale 1ns / 1ps

module zero_run_length_row_decoder_test;
   import zrlrd_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   int fail_count;
   int words_pending;
   int words_checked;
   int rows_checked;
   int clamped_rows;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int bytes_sent    = 0;
   int row_lengths   = 0;

   zero_run_length_row_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   zero_run_length_row_decoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .words_checked (words_checked),
      .rows_checked  (rows_checked),
      .clamped_rows  (clamped_rows)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // tvalid stays high after a transfer; the next call or a drain decides what follows
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_run(input logic [BYTE_W-1:0] count);
      send_byte('0);
      send_byte(count);
   endtask

   // hold the sender until every predicted word is out, then let a run load settle
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_row_bytes(input logic [CSR_W-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      row_lengths++;
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         1: begin
            send_idle_pct = 69;
            stall_pct     = 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct     = 69;
         end
         default: begin
            send_idle_pct = 22;
            stall_pct     = 22;
         end
      endcase
   endtask

   task automatic random_bytes(input int n);
      int i;
      int pick;
      i = 0;
      while (i < n) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_byte(BYTE_W'($urandom_range(255, 1)));
            i++;
         end else if (pick < 97) begin
            // mostly short runs, some long enough to cross many words or the row end
            send_run(BYTE_W'((pick < 85) ? $urandom_range(20) : $urandom_range(255)));
            i += 2;
         end else begin
            drain();
         end
      end
   endtask

   initial begin
      int settings[12];
      settings = '{13, 8, 64, 3, 100, 16383, 24, 1, 9, 40, 8192, 2};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset row length: literal extremes, empty run, longest run
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'h80);
      send_run(8'h00);
      send_run(8'hFF);
      send_run(8'h01);
      send_byte(8'h55);
      send_byte(8'hAA);
      // leave a marker pending; the write below must drop it with the partial word
      send_byte(8'h00);

      set_row_bytes(14'd1);
      send_byte(8'h05);
      send_run(8'h03);
      send_run(8'h01);

      // zero length behaves as one
      set_row_bytes(14'd0);
      send_byte(8'h09);

      // above the maximum behaves as the maximum
      set_row_bytes(14'h3FFF);
      send_byte(8'h11);

      set_row_bytes(14'd10);
      send_run(8'hFF);
      send_byte(8'hC3);
      send_run(8'h05);
      send_run(8'h08);

      foreach (settings[k]) begin
         set_row_bytes(CSR_W'(settings[k]));
         set_idle_mode(k % 4);
         random_bytes(28);
      end

      drain();
      $display("sent %0d compressed bytes across %0d row length settings",
         bytes_sent, row_lengths);
      $display("checked %0d row words, %0d complete rows, %0d rows with a clamped run",
         words_checked, rows_checked, clamped_rows);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
